FILE: rtl/matrix_multiply_transpose_sum_unit_defines.svh
`ifndef MATRIX_MULTIPLY_TRANSPOSE_SUM_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_TRANSPOSE_SUM_UNIT_DEFINES_SVH

// clocked assertion, quiet during reset
`define MMTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form
`define MMTS_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

FILE: rtl/mmts_pkg.sv
`timescale 1ns / 1ps

package mmts_pkg;

  localparam int MAX_DIM = 16;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = IDX_W + 1;
  localparam int ACC_W   = 36;
  localparam int RES_W   = 44;

  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;
  localparam logic [1:0] FUNC_READ    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NO_PROD  = 2'd2;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_INNER = 2'd1;
  localparam logic [1:0] CFG_COLS  = 2'd2;

  typedef struct packed {
    logic               vld;
    logic [IDX_W-1:0]   k;
    logic signed [15:0] a;
  } chain_t;

  typedef struct packed {
    logic cap;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: rtl/mmts_cell.sv
`timescale 1ns / 1ps

module mmts_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                b_we,
  input  logic [mmts_pkg::IDX_W-1:0]          b_addr,
  input  logic signed [15:0]                  b_wdata,
  input  mmts_pkg::cell_ctl_t                 ctl,
  input  mmts_pkg::chain_t                    chain_in,
  output mmts_pkg::chain_t                    chain_out,
  input  logic signed [mmts_pkg::ACC_W-1:0]   sh_in,
  output logic signed [mmts_pkg::ACC_W-1:0]   sh_out
);

  // one column of b, indexed by k
  logic signed [15:0] b_col [mmts_pkg::MAX_DIM];
  mmts_pkg::chain_t   chain_r;
  logic signed [31:0] prod_r;
  logic               pv_r;
  logic               pfirst_r;
  logic signed [mmts_pkg::ACC_W-1:0] acc_r;
  logic signed [mmts_pkg::ACC_W-1:0] sh_r;
  logic signed [15:0] b_rd;
  logic signed [31:0] prod_nxt;

  assign b_rd     = b_col[chain_in.k];
  assign prod_nxt = chain_in.a * b_rd;

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_col[b_addr] <= b_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r.vld <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      chain_r.vld <= chain_in.vld;
      pv_r        <= chain_in.vld;
    end
    chain_r.k <= chain_in.k;
    chain_r.a <= chain_in.a;
    prod_r    <= prod_nxt;
    pfirst_r  <= (chain_in.k == '0);
  end

  // first term of a dot product restarts the accumulator
  always_ff @(posedge clk) begin
    if (pv_r) begin
      if (pfirst_r) begin
        acc_r <= mmts_pkg::ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + mmts_pkg::ACC_W'(prod_r);
      end
    end
    if (ctl.cap) begin
      sh_r <= acc_r;
    end else if (ctl.shift) begin
      sh_r <= sh_in;
    end
  end

  assign chain_out = chain_r;
  assign sh_out    = sh_r;

endmodule

FILE: rtl/matrix_multiply_transpose_sum_unit.sv
`timescale 1ns / 1ps
// channel  | direction | contents
// in_      | slave     | tdata: func, row, col, value
// out_     | master    | tdata: status, result_value
// cfg_     | write     | rows_n, inner_len, cols_m
// loads answer straight from idle; a read passes through S_RD (registered product memory read).
// a compute runs S_FEED, S_WAIT and S_DRAIN for every row, then S_DONE:
// per row, a elements stream into the cell row, the chain settles, then results
// shift out of cell 0 one column a cycle into the product memory and the running sum.
// reset is synchronous; no clearing pass. a held result blocks new items only
// while out_tready stays low.

`include "matrix_multiply_transpose_sum_unit_defines.svh"

module matrix_multiply_transpose_sum_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // func[1:0], row[5:2], col[9:6], value[25:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], result_value[45:2]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [4:0]  cfg_wdata
);

  localparam int IW     = mmts_pkg::IDX_W;
  localparam int DW     = mmts_pkg::DIM_W;
  localparam int MD     = mmts_pkg::MAX_DIM;
  localparam int AW     = mmts_pkg::ACC_W;
  localparam int RW     = mmts_pkg::RES_W;
  localparam int SUM_W  = RW + 2;
  localparam int WAIT_C = MD + 4;
  localparam int WCW    = $clog2(WAIT_C + 1);
  localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-RW+1){1'b0}}, {(RW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO = {{(SUM_W-RW+1){1'b1}}, {(RW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_FEED, S_WAIT, S_DRAIN, S_DONE
  } state_t;

  state_t state_r;
  logic [4:0] rows_r, inner_r, cols_r;
  logic       pvalid_r;
  logic       out_vld_r;
  logic [1:0] out_st_r;
  logic signed [RW-1:0] out_val_r;
  logic [IW-1:0] i_r, k_r, j_r;
  logic [WCW-1:0] w_r;
  logic signed [SUM_W-1:0] sum_r;

  logic signed [15:0] a_mem [MD*MD];
  logic signed [AW-1:0] c_mem [MD*MD];
  logic signed [15:0] a_rd_r;
  logic signed [AW-1:0] c_rd_r;
  logic iss_vld_r;
  logic [IW-1:0] iss_k_r;

  logic [1:0] f_func;
  logic [IW-1:0] f_row, f_col;
  logic signed [15:0] f_val;
  logic [DW-1:0] n_d, l_d, m_d, sq_d;
  logic accept, out_free;
  logic range_a, range_b, range_c;
  logic [2*IW-1:0] c_waddr;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [RW-1:0] sum_sat;

  mmts_pkg::chain_t    chain [MD+1];
  logic signed [AW-1:0] sh [MD+1];
  mmts_pkg::cell_ctl_t ctl;

  function automatic logic [DW-1:0] dim_clamp(input logic [4:0] v);
    if (v == 5'd0) return DW'(1);
    if ({1'b0, v} > 6'(MD)) return DW'(MD);
    return DW'(v);
  endfunction

  assign f_func = in_tdata[1:0];
  assign f_row  = in_tdata[5:2];
  assign f_col  = in_tdata[9:6];
  assign f_val  = in_tdata[25:10];

  assign n_d  = dim_clamp(rows_r);
  assign l_d  = dim_clamp(inner_r);
  assign m_d  = dim_clamp(cols_r);
  assign sq_d = (n_d < m_d) ? n_d : m_d;

  assign range_a = ({1'b0, f_row} < n_d) && ({1'b0, f_col} < l_d);
  assign range_b = ({1'b0, f_row} < l_d) && ({1'b0, f_col} < m_d);
  assign range_c = ({1'b0, f_row} < n_d) && ({1'b0, f_col} < m_d);

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  // leading square part is stored across the diagonal
  assign c_waddr = (({1'b0, i_r} < sq_d) && ({1'b0, j_r} < sq_d)) ? {j_r, i_r} : {i_r, j_r};
  assign sum_nxt = sum_r + SUM_W'(sh[0]);
  assign sum_sat = (sum_r > SUM_HI) ? RW'(SUM_HI) :
                   (sum_r < SUM_LO) ? RW'(SUM_LO) :
                   RW'(sum_r);

  assign ctl.cap   = (state_r == S_WAIT) && (w_r == WCW'(WAIT_C - 1));
  assign ctl.shift = (state_r == S_DRAIN);

  assign chain[0].vld = iss_vld_r;
  assign chain[0].k   = iss_k_r;
  assign chain[0].a   = a_rd_r;
  assign sh[MD]       = '0;

  for (genvar g = 0; g < MD; g++) begin : g_cell
    mmts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .b_we     (accept && (f_func == mmts_pkg::FUNC_LOAD_B) && range_b &&
                 (f_col == IW'(g))),
      .b_addr   (f_row),
      .b_wdata  (f_val),
      .ctl      (ctl),
      .chain_in (chain[g]),
      .chain_out(chain[g+1]),
      .sh_in    (sh[g+1]),
      .sh_out   (sh[g])
    );
  end

  always_ff @(posedge clk) begin
    if (accept && (f_func == mmts_pkg::FUNC_LOAD_A) && range_a) begin
      a_mem[{f_row, f_col}] <= f_val;
    end
    a_rd_r <= a_mem[{i_r, k_r}];
    if (state_r == S_DRAIN) begin
      c_mem[c_waddr] <= sh[0];
    end
    c_rd_r <= c_mem[{f_row, f_col}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rows_r    <= 5'd16;
      inner_r   <= 5'd16;
      cols_r    <= 5'd16;
      pvalid_r  <= 1'b0;
      out_vld_r <= 1'b0;
      iss_vld_r <= 1'b0;
      i_r <= '0; k_r <= '0; j_r <= '0; w_r <= '0;
      sum_r <= '0;
    end else begin
      iss_vld_r <= 1'b0;
      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          mmts_pkg::CFG_ROWS:  begin rows_r  <= cfg_wdata; pvalid_r <= 1'b0; end
          mmts_pkg::CFG_INNER: begin inner_r <= cfg_wdata; pvalid_r <= 1'b0; end
          mmts_pkg::CFG_COLS:  begin cols_r  <= cfg_wdata; pvalid_r <= 1'b0; end
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_val_r <= '0;
            unique case (f_func)
              mmts_pkg::FUNC_LOAD_A: begin
                out_vld_r <= 1'b1;
                out_st_r  <= range_a ? mmts_pkg::ST_OK : mmts_pkg::ST_RANGE;
              end
              mmts_pkg::FUNC_LOAD_B: begin
                out_vld_r <= 1'b1;
                out_st_r  <= range_b ? mmts_pkg::ST_OK : mmts_pkg::ST_RANGE;
              end
              mmts_pkg::FUNC_COMPUTE: begin
                i_r     <= '0;
                k_r     <= '0;
                sum_r   <= '0;
                state_r <= S_FEED;
              end
              default: begin
                if (!pvalid_r) begin
                  out_vld_r <= 1'b1;
                  out_st_r  <= mmts_pkg::ST_NO_PROD;
                end else if (!range_c) begin
                  out_vld_r <= 1'b1;
                  out_st_r  <= mmts_pkg::ST_RANGE;
                end else begin
                  state_r <= S_RD;
                end
              end
            endcase
          end
        end
        S_RD: begin
          out_vld_r <= 1'b1;
          out_st_r  <= mmts_pkg::ST_OK;
          out_val_r <= RW'(c_rd_r);
          state_r   <= S_IDLE;
        end
        S_FEED: begin
          iss_vld_r <= 1'b1;
          iss_k_r   <= k_r;
          if ({1'b0, k_r} == l_d - DW'(1)) begin
            k_r     <= '0;
            w_r     <= '0;
            state_r <= S_WAIT;
          end else begin
            k_r <= k_r + IW'(1);
          end
        end
        S_WAIT: begin
          w_r <= w_r + WCW'(1);
          if (ctl.cap) begin
            j_r     <= '0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          sum_r <= sum_nxt;
          j_r   <= j_r + IW'(1);
          if ({1'b0, j_r} == m_d - DW'(1)) begin
            if ({1'b0, i_r} == n_d - DW'(1)) begin
              state_r <= S_DONE;
            end else begin
              i_r     <= i_r + IW'(1);
              state_r <= S_FEED;
            end
          end
        end
        S_DONE: begin
          out_vld_r <= 1'b1;
          out_st_r  <= mmts_pkg::ST_OK;
          out_val_r <= sum_sat;
          pvalid_r  <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_val_r, out_st_r};

  `MMTS_ASSERT_IMP(a_busy_no_ready, state_r != S_IDLE, !in_tready, "item taken while busy")
  `MMTS_ASSERT_IMP(a_done_out, state_r == S_DONE, ##1 out_tvalid, "compute gave no result")
  `MMTS_ASSERT_IMP(a_drain_col, state_r == S_DRAIN, {1'b0, j_r} < m_d, "drain past last column")
  `MMTS_ASSERT(a_iss_feed, iss_vld_r |-> $past(state_r == S_FEED), "stray chain item")

endmodule
